[src/assert_macros.svh]
// Assertion helpers used by the RTL core.
// Each macro takes a label, a clock, an active-low reset, a property or condition and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property at every rising clock edge while reset is released.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that a condition never holds while reset is released.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[src/pdsr_pkg.sv]
package pdsr_pkg;

    // Field widths.
    localparam int PressW   = 24;
    localparam int RawVarW  = 32;
    localparam int DepthW   = 32;
    localparam int VarW     = 40;
    localparam int KindW    = 2;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int InDataW  = PressW + RawVarW;
    localparam int OutDataW = DepthW + VarW;

    // Shared multiplier operand and product widths.
    localparam int MulAW = 32;
    localparam int MulBW = 24;
    localparam int MulPW = MulAW + MulBW;

    // Input item kinds.
    localparam logic IN_SAMPLE    = 1'b0;
    localparam logic IN_CALIBRATE = 1'b1;

    // Result kinds.
    localparam logic [KindW-1:0] RES_DEPTH    = 2'd0;
    localparam logic [KindW-1:0] RES_CAL_DONE = 2'd1;
    localparam logic [KindW-1:0] RES_CAL_FAIL = 2'd2;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_PRESSURE_GAIN  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SPIKE_LIMIT    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_REJECTIONS = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ATM_REFERENCE  = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MM_PER_PASCAL  = 3'd4;

    // Configuration reset values.
    localparam logic [23:0] RST_PRESSURE_GAIN  = 24'd65536;
    localparam logic [23:0] RST_SPIKE_LIMIT    = 24'd0;
    localparam logic [7:0]  RST_MAX_REJECTIONS = 8'd5;
    localparam logic [23:0] RST_ATM_REFERENCE  = 24'd101325;
    localparam logic [23:0] RST_MM_PER_PASCAL  = 24'd1668556;

endpackage

[src/pressure_depth_with_spike_reject_core.sv]
// Channel   Direction  Handshake                   Payload
// s_        in         s_tvalid / s_tready         s_tuser: kind; s_tdata: pressure, variance
// m_        out        m_tvalid / m_tready         m_tuser: result_kind; m_tdata: depth, var
// cfg_      in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// A pressure sample runs through the whole sequencer from its acceptance to the earliest next acceptance;
// the result appears in the output register at the end of that run. The run's length is set by the
// nine products that one shared 32x24 multiplier computes in turn under the sequencer.
// A rejected spike returns to idle from the check step; a calibrate request goes straight to emit.
// Reset is synchronous and active low; it restores the register defaults and clears state.
// The block waits in its emit step while a previous result is still not taken.
`include "assert_macros.svh"

module pressure_depth_with_spike_reject_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pdsr_pkg::InDataW-1:0]  s_tdata,   // [23:0] raw_pressure, [55:24] raw_variance
    input  logic                          s_tuser,   // [0] kind
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pdsr_pkg::OutDataW-1:0] m_tdata,   // [31:0] depth_mm, [71:32] depth_variance
    output logic [pdsr_pkg::KindW-1:0]    m_tuser,   // [1:0] result_kind
    // Configuration write channel.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pdsr_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [pdsr_pkg::CfgDataW-1:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_CHECK,
        ST_MUL_D,
        ST_MUL_V1,
        ST_V2_LO,
        ST_V2_HI,
        ST_V2_SUM,
        ST_MS_LO,
        ST_MS_HI,
        ST_MS_SUM,
        ST_EMIT
    } state_t;

    // Configuration registers.
    logic [23:0] pressure_gain_reg;
    logic [23:0] spike_limit_reg;
    logic [7:0]  max_rejections_reg;
    logic [23:0] atm_reference_reg;
    logic [23:0] mm_per_pascal_reg;

    // Architectural state.
    logic [23:0] last_sample_reg;
    logic        sample_seen_reg;
    logic [23:0] cal_reference_reg;
    logic        is_calibrated_reg;
    logic [7:0]  reject_run_reg;

    // Sequencer and datapath registers.
    state_t                      state_reg;
    logic                        pass_reg;
    logic [23:0]                 raw_p_reg;
    logic [31:0]                 raw_v_reg;
    logic [23:0]                 mag_reg;
    logic                        positive_reg;
    logic [pdsr_pkg::MulPW-1:0]  prod_reg;
    logic [47:0]                 op_reg;
    logic [47:0]                 acc_reg;
    logic [pdsr_pkg::KindW-1:0]  res_kind_reg;
    logic [pdsr_pkg::DepthW-1:0] res_depth_reg;
    logic [pdsr_pkg::VarW-1:0]   res_var_reg;

    // Output register.
    logic                          m_tvalid_reg;
    logic [pdsr_pkg::OutDataW-1:0] m_tdata_reg;
    logic [pdsr_pkg::KindW-1:0]    m_tuser_reg;

    // Combinational helpers.
    logic [pdsr_pkg::MulAW-1:0] mult_a;
    logic [pdsr_pkg::MulBW-1:0] mult_b;
    logic [23:0]                p_sat;
    logic [23:0]                diff;
    logic                       is_spike;
    logic [23:0]                ref_sel;
    logic                       ref_ge;
    logic [24:0]                depth_q;
    logic [31:0]                depth_val;
    logic [47:0]                sum48;
    logic                       s_accept;
    logic                       out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressure_gain_reg  <= pdsr_pkg::RST_PRESSURE_GAIN;
            spike_limit_reg    <= pdsr_pkg::RST_SPIKE_LIMIT;
            max_rejections_reg <= pdsr_pkg::RST_MAX_REJECTIONS;
            atm_reference_reg  <= pdsr_pkg::RST_ATM_REFERENCE;
            mm_per_pascal_reg  <= pdsr_pkg::RST_MM_PER_PASCAL;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                pdsr_pkg::REG_PRESSURE_GAIN:  pressure_gain_reg  <= cfg_data;
                pdsr_pkg::REG_SPIKE_LIMIT:    spike_limit_reg    <= cfg_data;
                pdsr_pkg::REG_MAX_REJECTIONS: max_rejections_reg <= cfg_data[7:0];
                pdsr_pkg::REG_ATM_REFERENCE:  atm_reference_reg  <= cfg_data;
                pdsr_pkg::REG_MM_PER_PASCAL:  mm_per_pascal_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mult_a = '0;
        mult_b = mm_per_pascal_reg;
        case (state_reg)
            ST_MUL_P: begin
                mult_a = {8'b0, raw_p_reg};
                mult_b = pressure_gain_reg;
            end
            ST_MUL_D: begin
                mult_a = {8'b0, mag_reg};
            end
            ST_MUL_V1: begin
                mult_a = raw_v_reg;
                mult_b = pressure_gain_reg;
            end
            ST_V2_LO: begin
                // Low 24 bits of v1, taken straight from the product.
                mult_a = {8'b0, prod_reg[39:16]};
                mult_b = pressure_gain_reg;
            end
            ST_V2_HI: begin
                mult_a = {16'b0, op_reg[39:24]};
                mult_b = pressure_gain_reg;
            end
            ST_MS_LO: begin
                mult_a = {8'b0, op_reg[23:0]};
            end
            ST_MS_HI: begin
                mult_a = {8'b0, op_reg[47:24]};
            end
            default: ;
        endcase
    end

    // Saturated pressure, spike test and reference offset.
    always_comb begin
        p_sat    = (prod_reg[55:40] != '0) ? 24'hFF_FFFF : prod_reg[39:16];
        diff     = (p_sat >= last_sample_reg) ? (p_sat - last_sample_reg)
                                              : (last_sample_reg - p_sat);
        is_spike = (spike_limit_reg != '0) && sample_seen_reg && (diff > spike_limit_reg)
                   && (reject_run_reg < max_rejections_reg);
        ref_sel  = is_calibrated_reg ? cal_reference_reg : atm_reference_reg;
        ref_ge   = (ref_sel >= p_sat);
    end

    // Depth rounding: the product stays below 2^48, so the magnitude fits 25 bits
    // and the 32-bit result never saturates.
    always_comb begin
        depth_q   = {1'b0, prod_reg[47:24]} + {24'b0, prod_reg[23]};
        depth_val = positive_reg ? {7'b0, depth_q} : (~{7'b0, depth_q} + 32'd1);
        sum48     = prod_reg[47:0] + acc_reg;
    end

    // Sequencer, datapath and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            pass_reg          <= 1'b0;
            last_sample_reg   <= '0;
            sample_seen_reg   <= 1'b0;
            cal_reference_reg <= '0;
            is_calibrated_reg <= 1'b0;
            reject_run_reg    <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            // In the emit step a taken result is replaced by the new one below.
            if (m_tvalid_reg && m_tready && state_reg != ST_EMIT) begin
                m_tvalid_reg <= 1'b0;
            end
            prod_reg <= pdsr_pkg::MulPW'({24'b0, mult_a} * {32'b0, mult_b});

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        raw_p_reg <= s_tdata[23:0];
                        raw_v_reg <= s_tdata[55:24];
                        if (s_tuser == pdsr_pkg::IN_CALIBRATE) begin
                            res_depth_reg <= '0;
                            res_var_reg   <= '0;
                            if (!sample_seen_reg) begin
                                res_kind_reg <= pdsr_pkg::RES_CAL_FAIL;
                            end else begin
                                res_kind_reg      <= pdsr_pkg::RES_CAL_DONE;
                                cal_reference_reg <= last_sample_reg;
                                is_calibrated_reg <= 1'b1;
                                reject_run_reg    <= '0;
                            end
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_MUL_P;
                        end
                    end
                end
                ST_MUL_P: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (is_spike) begin
                        // Dropped sample: count it and produce nothing.
                        reject_run_reg <= reject_run_reg + 8'd1;
                        state_reg      <= ST_IDLE;
                    end else begin
                        reject_run_reg  <= '0;
                        last_sample_reg <= p_sat;
                        sample_seen_reg <= 1'b1;
                        positive_reg    <= ref_ge;
                        mag_reg         <= ref_ge ? (ref_sel - p_sat) : (p_sat - ref_sel);
                        state_reg       <= ST_MUL_D;
                    end
                end
                ST_MUL_D: begin
                    state_reg <= ST_MUL_V1;
                end
                ST_MUL_V1: begin
                    res_kind_reg  <= pdsr_pkg::RES_DEPTH;
                    res_depth_reg <= depth_val;
                    state_reg     <= ST_V2_LO;
                end
                ST_V2_LO: begin
                    // v1 = (raw_variance * gain) >> 16.
                    op_reg    <= {8'b0, prod_reg[55:16]};
                    state_reg <= ST_V2_HI;
                end
                ST_V2_HI: begin
                    acc_reg   <= {16'b0, prod_reg[47:16]};
                    state_reg <= ST_V2_SUM;
                end
                ST_V2_SUM: begin
                    // v2 = (hi * gain) << 8 plus (lo * gain) >> 16.
                    op_reg    <= {prod_reg[39:0], 8'b0} + acc_reg;
                    pass_reg  <= 1'b0;
                    state_reg <= ST_MS_LO;
                end
                ST_MS_LO: begin
                    state_reg <= ST_MS_HI;
                end
                ST_MS_HI: begin
                    acc_reg   <= {24'b0, prod_reg[47:24]};
                    state_reg <= ST_MS_SUM;
                end
                ST_MS_SUM: begin
                    // Two passes of hi * m plus (lo * m) >> 24 give v3, then v4.
                    if (!pass_reg) begin
                        op_reg    <= sum48;
                        pass_reg  <= 1'b1;
                        state_reg <= ST_MS_LO;
                    end else begin
                        res_var_reg <= (sum48[47:40] != '0) ? '1 : sum48[39:0];
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {res_var_reg, res_depth_reg};
                        m_tuser_reg  <= res_kind_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A rejected spike raises the run count by exactly one.
    `ASSERT_PROP(a_reject_count, aclk, aresetn, (state_reg == ST_CHECK && is_spike) |=> (reject_run_reg == $past(reject_run_reg) + 8'd1), "reject run did not advance")

    // A new result appears only from the emit step.
    `ASSERT_PROP(a_emit_source, aclk, aresetn, (m_tvalid_reg && !$past(m_tvalid_reg)) |-> $past(state_reg == ST_EMIT), "result appeared outside emit")

    // Calibration results carry zero depth and variance.
    `ASSERT_PROP(a_cal_zero, aclk, aresetn, (m_tvalid_reg && m_tuser_reg != pdsr_pkg::RES_DEPTH) |-> (m_tdata_reg == '0), "calibration result with data")

    // Once a sample has been accepted the flag stays set.
    `ASSERT_PROP(a_seen_sticky, aclk, aresetn, sample_seen_reg |=> sample_seen_reg, "sample seen flag cleared")

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    // One expected result of the depth block.
    typedef struct packed {
        logic [pdsr_pkg::KindW-1:0]  kind;
        logic [pdsr_pkg::DepthW-1:0] depth;
        logic [pdsr_pkg::VarW-1:0]   variance;
    } depth_result_t;

    localparam logic [23:0] PRESS_MAX = 24'hFFFFFF;
    localparam int          SETTLE_CYCLES = 24;
    localparam int          RANDOM_PHASES = 6;
    localparam int          ITEMS_PER_PHASE = 150;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [pdsr_pkg::InDataW-1:0]    s_tdata = '0;
    logic                            s_tuser = pdsr_pkg::IN_SAMPLE;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [pdsr_pkg::OutDataW-1:0]   m_tdata;
    logic [pdsr_pkg::KindW-1:0]      m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [pdsr_pkg::CfgIdxW-1:0]    cfg_index = '0;
    logic [pdsr_pkg::CfgDataW-1:0]   cfg_data = '0;

    // Predicted register contents.
    logic [23:0] cfg_gain;
    logic [23:0] cfg_spike_limit;
    logic [7:0]  cfg_max_rej;
    logic [23:0] cfg_atm_ref;
    logic [23:0] cfg_mm_per_pa;

    // Predicted filter and calibration state.
    logic [23:0] last_pres;
    logic        pres_seen;
    logic [23:0] cal_ref;
    logic        cal_valid;
    logic [7:0]  reject_count;

    depth_result_t pending_results[$];
    int            error_count = 0;
    bit            src_idle_on = 1'b1;
    bit            sink_idle_on = 1'b1;
    int            sink_hold = 0;

    pressure_depth_with_spike_reject_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(input bit enabled);
        int roll;
        if (!enabled) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void reset_depth_model();
        cfg_gain        = pdsr_pkg::RST_PRESSURE_GAIN;
        cfg_spike_limit = pdsr_pkg::RST_SPIKE_LIMIT;
        cfg_max_rej     = pdsr_pkg::RST_MAX_REJECTIONS;
        cfg_atm_ref     = pdsr_pkg::RST_ATM_REFERENCE;
        cfg_mm_per_pa   = pdsr_pkg::RST_MM_PER_PASCAL;
        last_pres       = '0;
        pres_seen       = 1'b0;
        cal_ref         = '0;
        cal_valid       = 1'b0;
        reject_count    = '0;
    endfunction

    // Works out the result of one request and advances the predicted state.
    // Returns 0 when the request is dropped as a spike.
    function automatic bit predict_depth(input logic item_kind, input logic [23:0] raw_p,
                                         input logic [31:0] raw_v,
                                         output depth_result_t res);
        logic [47:0]  scaled;
        logic [23:0]  pres;
        logic [23:0]  jump;
        logic [23:0]  base;
        logic [23:0]  mag;
        logic [48:0]  prod;
        logic [24:0]  quot;
        logic [127:0] v;
        logic         positive;
        res = '0;
        if (item_kind == pdsr_pkg::IN_CALIBRATE) begin
            if (!pres_seen) begin
                res.kind = pdsr_pkg::RES_CAL_FAIL;
                return 1'b1;
            end
            cal_ref      = last_pres;
            cal_valid    = 1'b1;
            reject_count = '0;
            res.kind     = pdsr_pkg::RES_CAL_DONE;
            return 1'b1;
        end

        // Gain in Q8.16, saturated to 24 bits.
        scaled = 48'(raw_p) * 48'(cfg_gain);
        pres = (scaled[47:40] != '0) ? PRESS_MAX : scaled[39:16];

        // Spike filter against the last accepted pressure.
        if (cfg_spike_limit != '0 && pres_seen) begin
            jump = (pres >= last_pres) ? pres - last_pres : last_pres - pres;
            if (jump > cfg_spike_limit && reject_count < cfg_max_rej) begin
                reject_count++;
                return 1'b0;
            end
        end
        reject_count = '0;
        last_pres    = pres;
        pres_seen    = 1'b1;

        // Depth rounds half away from zero; the magnitude stays below 2^25.
        base     = cal_valid ? cal_ref : cfg_atm_ref;
        positive = (base >= pres);
        mag      = positive ? base - pres : pres - base;
        prod     = 49'(mag) * 49'(cfg_mm_per_pa) + 49'(24'h800000);
        quot     = prod[48:24];
        res.kind  = pdsr_pkg::RES_DEPTH;
        res.depth = positive ? {7'd0, quot} : -{7'd0, quot};

        // Variance goes through four truncating stages, then saturates to 40 bits.
        v = 128'(raw_v) * 128'(cfg_gain);
        v = v >> 16;
        v = (v * 128'(cfg_gain)) >> 16;
        v = (v * 128'(cfg_mm_per_pa)) >> 24;
        v = (v * 128'(cfg_mm_per_pa)) >> 24;
        res.variance = (v > 128'(40'hFFFFFFFFFF)) ? 40'hFFFFFFFFFF : v[39:0];
        return 1'b1;
    endfunction

    // Sends one request; starts and ends just after a falling edge.
    task automatic send_request(input logic item_kind, input logic [23:0] raw_p,
                                input logic [31:0] raw_v);
        int            gap;
        depth_result_t res;
        gap = pick_gap(src_idle_on);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = item_kind;
        s_tdata  = {raw_v, raw_p};
        do @(posedge aclk); while (!s_tready);
        if (predict_depth(item_kind, raw_p, raw_v, res)) begin
            pending_results.push_back(res);
        end
        @(negedge aclk);
    endtask

    // Waits until every expected result is in and the block has gone quiet.
    task automatic settle_block();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [pdsr_pkg::CfgIdxW-1:0] idx,
                             input logic [23:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            pdsr_pkg::REG_PRESSURE_GAIN:  cfg_gain        = value;
            pdsr_pkg::REG_SPIKE_LIMIT:    cfg_spike_limit = value;
            pdsr_pkg::REG_MAX_REJECTIONS: cfg_max_rej     = value[7:0];
            pdsr_pkg::REG_ATM_REFERENCE:  cfg_atm_ref     = value;
            pdsr_pkg::REG_MM_PER_PASCAL:  cfg_mm_per_pa   = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Raw reading that lands near a target pressure under the current gain.
    function automatic logic [23:0] raw_for_pressure(input longint target);
        longint raw;
        if (cfg_gain == '0) begin
            return 24'($urandom);
        end
        raw = (target * 65536) / longint'(cfg_gain);
        return (raw > longint'(PRESS_MAX)) ? PRESS_MAX : 24'(raw);
    endfunction

    function automatic logic [31:0] pick_variance();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            return '0;
        end else if (roll == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic test_calibrate_without_data();
        send_request(pdsr_pkg::IN_CALIBRATE, 24'($urandom), $urandom);
    endtask

    task automatic test_depth_extremes();
        send_request(pdsr_pkg::IN_SAMPLE, 24'd0, 32'd0);
        send_request(pdsr_pkg::IN_SAMPLE, PRESS_MAX, 32'hFFFFFFFF);
    endtask

    // Half a millimeter per pascal against a reference of 3 Pa gives ties.
    task automatic test_depth_rounding();
        settle_block();
        write_reg(pdsr_pkg::REG_MM_PER_PASCAL, 24'h800000);
        write_reg(pdsr_pkg::REG_ATM_REFERENCE, 24'd3);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd0, 32'h55555555);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd6, 32'hAAAAAAAA);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd4, 32'd1);
    endtask

    task automatic test_spike_filter();
        settle_block();
        write_reg(pdsr_pkg::REG_SPIKE_LIMIT, 24'd100);
        write_reg(pdsr_pkg::REG_MAX_REJECTIONS, 24'd2);
        // Two drops, then the run is long enough and the step is taken.
        send_request(pdsr_pkg::IN_SAMPLE, 24'd1000, 32'd7);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd1000, 32'd7);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd1000, 32'd7);
        // A jump of exactly the limit passes; one more is dropped.
        send_request(pdsr_pkg::IN_SAMPLE, 24'd1100, 32'd9);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd1201, 32'd9);
        // Calibration clears the rejection run and moves the reference.
        send_request(pdsr_pkg::IN_CALIBRATE, 24'd0, 32'd0);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd1300, 32'd11);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd1200, 32'd11);
        // The upper data bits are dropped, so no rejection is allowed.
        settle_block();
        write_reg(pdsr_pkg::REG_MAX_REJECTIONS, 24'hFFFF00);
        send_request(pdsr_pkg::IN_SAMPLE, 24'd5000, 32'd13);
    endtask

    task automatic test_gain_saturation();
        settle_block();
        write_reg(pdsr_pkg::REG_PRESSURE_GAIN, PRESS_MAX);
        write_reg(pdsr_pkg::REG_SPIKE_LIMIT, 24'd0);
        write_reg(pdsr_pkg::REG_MM_PER_PASCAL, PRESS_MAX);
        send_request(pdsr_pkg::IN_SAMPLE, PRESS_MAX, 32'hFFFFFFFF);
        settle_block();
        write_reg(pdsr_pkg::REG_PRESSURE_GAIN, 24'd0);
        write_reg(pdsr_pkg::REG_MM_PER_PASCAL + 3'd3, PRESS_MAX);
        send_request(pdsr_pkg::IN_SAMPLE, 24'h555555, 32'hAAAAAAAA);
    endtask

    task automatic configure_phase(input int phase);
        settle_block();
        case (phase)
            0: begin
                write_reg(pdsr_pkg::REG_PRESSURE_GAIN, 24'd65536);
                write_reg(pdsr_pkg::REG_SPIKE_LIMIT, 24'd1000);
                write_reg(pdsr_pkg::REG_MAX_REJECTIONS, 24'd3);
                write_reg(pdsr_pkg::REG_ATM_REFERENCE, pdsr_pkg::RST_ATM_REFERENCE);
                write_reg(pdsr_pkg::REG_MM_PER_PASCAL, pdsr_pkg::RST_MM_PER_PASCAL);
            end
            1: begin
                write_reg(pdsr_pkg::REG_PRESSURE_GAIN, PRESS_MAX);
                write_reg(pdsr_pkg::REG_SPIKE_LIMIT, PRESS_MAX);
                write_reg(pdsr_pkg::REG_MAX_REJECTIONS, PRESS_MAX);
                write_reg(pdsr_pkg::REG_ATM_REFERENCE, PRESS_MAX);
                write_reg(pdsr_pkg::REG_MM_PER_PASCAL, PRESS_MAX);
            end
            2: begin
                write_reg(pdsr_pkg::REG_PRESSURE_GAIN, 24'd0);
                write_reg(pdsr_pkg::REG_SPIKE_LIMIT, 24'd0);
                write_reg(pdsr_pkg::REG_MAX_REJECTIONS, 24'd0);
                write_reg(pdsr_pkg::REG_ATM_REFERENCE, 24'd0);
                write_reg(pdsr_pkg::REG_MM_PER_PASCAL, 24'd0);
            end
            default: begin
                write_reg(pdsr_pkg::REG_PRESSURE_GAIN, 24'($urandom_range(16384, 262144)));
                write_reg(pdsr_pkg::REG_SPIKE_LIMIT, 24'($urandom_range(1, 20000)));
                write_reg(pdsr_pkg::REG_MAX_REJECTIONS, 24'($urandom));
                write_reg(pdsr_pkg::REG_ATM_REFERENCE, 24'($urandom));
                write_reg(pdsr_pkg::REG_MM_PER_PASCAL, 24'($urandom));
            end
        endcase
        // Indexes past the last register must leave everything unchanged.
        write_reg(pdsr_pkg::REG_MM_PER_PASCAL + 3'($urandom_range(1, 3)), 24'($urandom));
    endtask

    // Mostly steady readings with bursts of spikes, some calibrations and noise.
    task automatic test_random_traffic();
        int     burst_left;
        int     roll;
        int     cap;
        longint span;
        longint target;
        longint spike_target;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure_phase(phase);
            src_idle_on  = (phase != 3);
            sink_idle_on = (phase != 3);
            burst_left   = 0;
            spike_target = 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(0, 99);
                if (burst_left > 0) begin
                    burst_left--;
                    send_request(pdsr_pkg::IN_SAMPLE, raw_for_pressure(spike_target),
                                 pick_variance());
                end else if (roll < 8) begin
                    send_request(pdsr_pkg::IN_CALIBRATE, 24'($urandom), $urandom);
                end else if (roll < 16) begin
                    send_request(pdsr_pkg::IN_SAMPLE, 24'($urandom), $urandom);
                end else if (roll < 26) begin
                    span = longint'(cfg_spike_limit) + 1 + $urandom_range(0, 1000);
                    if (longint'(last_pres) + span <= longint'(PRESS_MAX)) begin
                        spike_target = longint'(last_pres) + span;
                    end else if (longint'(last_pres) >= span) begin
                        spike_target = longint'(last_pres) - span;
                    end else begin
                        spike_target = $urandom_range(0, int'(PRESS_MAX));
                    end
                    cap = (cfg_max_rej > 8) ? 8 : int'(cfg_max_rej);
                    burst_left = $urandom_range(0, cap + 1);
                    send_request(pdsr_pkg::IN_SAMPLE, raw_for_pressure(spike_target),
                                 pick_variance());
                end else begin
                    span = (cfg_spike_limit != '0) ? longint'(cfg_spike_limit) : 5000;
                    target = longint'($urandom_range(0, int'(span)));
                    target = ($urandom_range(0, 1) == 1) ? longint'(last_pres) + target
                                                         : longint'(last_pres) - target;
                    if (target < 0) begin
                        target = 0;
                    end else if (target > longint'(PRESS_MAX)) begin
                        target = longint'(PRESS_MAX);
                    end
                    send_request(pdsr_pkg::IN_SAMPLE, raw_for_pressure(target),
                                 pick_variance());
                end
            end
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Result side stalls at random.
    always @(negedge aclk) begin
        if (sink_hold == 0 && sink_idle_on && $urandom_range(0, 99) < 20) begin
            sink_hold = pick_gap(1'b1);
        end
        if (sink_hold > 0) begin
            m_tready = 1'b0;
            sink_hold--;
        end else begin
            m_tready = 1'b1;
        end
    end

    // Each result taken is compared with the oldest expectation.
    always @(posedge aclk) begin
        depth_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with none expected", 64'(m_tuser), 64'hFFFF);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind) begin
                    report_mismatch("result_kind", 64'(m_tuser), 64'(want.kind));
                end
                if (m_tdata[31:0] !== want.depth) begin
                    report_mismatch("depth_mm", 64'(m_tdata[31:0]), 64'(want.depth));
                end
                if (m_tdata[71:32] !== want.variance) begin
                    report_mismatch("depth_variance", 64'(m_tdata[71:32]),
                                    64'(want.variance));
                end
            end
        end
    end

    initial begin
        reset_depth_model();
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_calibrate_without_data();
        test_depth_extremes();
        test_depth_rounding();
        test_spike_filter();
        test_gain_saturation();
        test_random_traffic();

        settle_block();
        repeat (40) @(negedge aclk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/pdsr_pkg.sv
src/pressure_depth_with_spike_reject_core.sv
verif/testbench.sv
